// ===== rtl/tcw_pkg.sv =====
// package for the text console writer
// screen geometry, action and state codes, control and status structs
// no dependencies
package tcw_pkg;

  localparam int SCREEN_COLS   = 80;
  localparam int SCREEN_ROWS   = 25;
  localparam int CELL_COUNT    = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W        = $clog2(CELL_COUNT);
  localparam int COL_W         = 7;
  localparam int ROW_W         = 5;
  localparam int CHAR_W        = 8;
  localparam int ATTR_W        = 8;
  localparam int CELL_W        = 16;
  localparam int ACT_W         = 3;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 40;
  localparam int COPY_LAST     = (SCREEN_ROWS - 1) * SCREEN_COLS - 1;
  localparam int LAST_ROW_BASE = (SCREEN_ROWS - 1) * SCREEN_COLS;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT_CHAR   = 3'd0,
    ACT_BACKSPACE  = 3'd1,
    ACT_CLEAR      = 3'd2,
    ACT_WRITE_CELL = 3'd3,
    ACT_READ_CELL  = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RESP,
    ST_COPY,
    ST_DRAIN,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic item_load;
    logic exec;
    logic out_load;
    logic sweep_set;
    logic sweep_last_row;
    logic fill;
    logic copy;
  } cmd_t;

  typedef struct packed {
    act_e action;
    logic scroll;
    logic fill_done;
    logic copy_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/tcw_ctrl.sv =====
// controller of the text console writer
// sequences item execution, screen fill, scroll copy and result hand-off
// depends on tcw_pkg
module tcw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  tcw_pkg::status_t status_i,
  output tcw_pkg::cmd_t    cmd_o
);
  import tcw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        case (status_i.action)
          ACT_CLEAR: begin
            cmd_o.sweep_set = 1'b1;
            state_d         = ST_FILL;
          end
          ACT_READ_CELL: begin
            state_d = ST_RESP;
          end
          default: begin
            if (status_i.scroll) begin
              cmd_o.sweep_set = 1'b1;
              state_d         = ST_COPY;
            end else if (status_i.out_free) begin
              cmd_o.out_load = 1'b1;
              state_d        = ST_IDLE;
            end else begin
              state_d = ST_RESP;
            end
          end
        endcase
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_COPY: begin
        cmd_o.copy = 1'b1;
        if (status_i.copy_done) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.sweep_set      = 1'b1;
        cmd_o.sweep_last_row = 1'b1;
        state_d              = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_done) begin
          state_d = ST_RESP;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/tcw_datapath.sv =====
// datapath of the text console writer
// screen memory, cursor, attribute register, sweep counter and result register
// depends on tcw_pkg
module tcw_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [tcw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic [tcw_pkg::ACT_W-1:0]         s_axis_tuser,
  output logic [tcw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]        cfg_data_i,
  input  tcw_pkg::cmd_t                     cmd_i,
  output tcw_pkg::status_t                  status_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [ATTR_W-1:0] text_attr_q;

  act_e              act_q;
  logic [CHAR_W-1:0] char_q;
  logic [ATTR_W-1:0] attr_q;
  logic [COL_W-1:0]  col_in_q;
  logic [ROW_W-1:0]  row_in_q;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] cur_q_idx, cur_d_idx, cell_addr;
  logic              in_range, advance, scroll;
  logic              exec_we;
  logic [ADDR_W-1:0] exec_addr;
  logic [CELL_W-1:0] exec_data;

  logic [ADDR_W-1:0] sweep_q;
  logic              copy_pend_q;
  logic [ADDR_W-1:0] copy_waddr_q;

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  m_user_q;
  logic [CHAR_W-1:0]     serial_byte;
  logic                  serial_valid;
  logic [CELL_W-1:0]     cell_entry;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= RESET_ATTR;
    end else if (cfg_valid_i) begin
      text_attr_q <= cfg_data_i;
    end
  end

  // item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      act_q    <= act_e'(s_axis_tuser);
      char_q   <= s_axis_tdata[7:0];
      attr_q   <= s_axis_tdata[15:8];
      col_in_q <= s_axis_tdata[22:16];
      row_in_q <= s_axis_tdata[27:23];
    end
  end

  assign in_range  = ({1'b0, col_in_q} < (COL_W + 1)'(SCREEN_COLS)) &&
                     ({1'b0, row_in_q} < (ROW_W + 1)'(SCREEN_ROWS));
  assign cell_addr = ADDR_W'(row_in_q) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col_in_q);
  assign cur_q_idx = ADDR_W'(row_q) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col_q);
  assign cur_d_idx = ADDR_W'(row_d) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col_d);

  // cursor update and cell write of one item
  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    advance   = 1'b0;
    scroll    = 1'b0;
    exec_we   = 1'b0;
    exec_addr = cur_q_idx;
    exec_data = {text_attr_q, char_q};
    case (act_q)
      ACT_PUT_CHAR: begin
        if (char_q == NEWLINE_CODE) begin
          advance = 1'b1;
        end else begin
          exec_we = 1'b1;
          if (col_q == COL_W'(SCREEN_COLS - 1)) begin
            advance = 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
        if (advance) begin
          col_d = '0;
          if (row_q == ROW_W'(SCREEN_ROWS - 1)) begin
            scroll = 1'b1;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      ACT_BACKSPACE: begin
        if (col_q != '0) begin
          col_d = col_q - 1'b1;
        end else if (row_q != '0) begin
          row_d = row_q - 1'b1;
          col_d = COL_W'(SCREEN_COLS - 1);
        end
        exec_we   = 1'b1;
        exec_addr = cur_d_idx;
        exec_data = {text_attr_q, SPACE_CODE};
      end
      ACT_CLEAR: begin
        row_d = '0;
        col_d = '0;
      end
      ACT_WRITE_CELL: begin
        exec_we   = in_range;
        exec_addr = cell_addr;
        exec_data = {attr_q, char_q};
      end
      default: begin
        exec_we = 1'b0;
      end
    endcase
    if (!cmd_i.exec) begin
      row_d   = row_q;
      col_d   = col_q;
      exec_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // sweep counter for fill and scroll copy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      copy_pend_q <= 1'b0;
    end else begin
      copy_pend_q <= cmd_i.copy;
      if (cmd_i.sweep_set) begin
        sweep_q <= cmd_i.sweep_last_row ? ADDR_W'(LAST_ROW_BASE) : '0;
      end else if (cmd_i.fill || cmd_i.copy) begin
        sweep_q <= sweep_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    copy_waddr_q <= sweep_q;
  end

  // screen memory
  assign rd_addr = cmd_i.copy ? sweep_q + ADDR_W'(SCREEN_COLS) : cell_addr;

  always_comb begin
    mem_we    = 1'b1;
    mem_waddr = exec_addr;
    mem_wdata = exec_data;
    if (copy_pend_q) begin
      mem_waddr = copy_waddr_q;
      mem_wdata = rd_data_q;
    end else if (cmd_i.fill) begin
      mem_waddr = sweep_q;
      mem_wdata = BLANK_CELL;
    end else begin
      mem_we = exec_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  // result register
  assign serial_valid = (act_q == ACT_PUT_CHAR) || (act_q == ACT_BACKSPACE);
  assign serial_byte  = (act_q == ACT_PUT_CHAR)  ? char_q :
                        (act_q == ACT_BACKSPACE) ? SPACE_CODE : '0;
  assign cell_entry   = ((act_q == ACT_READ_CELL) && in_range) ? rd_data_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_data_q <= {(OUT_DATA_W - ADDR_W - CHAR_W - CELL_W)'(0),
                   cell_entry, serial_byte, cur_d_idx};
      m_user_q <= serial_valid;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  assign status_o.action    = act_q;
  assign status_o.scroll    = scroll;
  assign status_o.fill_done = (sweep_q == ADDR_W'(CELL_COUNT - 1));
  assign status_o.copy_done = (sweep_q == ADDR_W'(COPY_LAST));
  assign status_o.out_free  = !m_valid_q || m_axis_tready;

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, row_q} < (ROW_W + 1)'(SCREEN_ROWS)) &&
    ({1'b0, col_q} < (COL_W + 1)'(SCREEN_COLS)))
    else $error("cursor out of screen");

  a_write_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({copy_pend_q, cmd_i.fill, exec_we}))
    else $error("screen write port collision");

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!m_valid_q || m_axis_tready))
    else $error("result loaded over a pending item");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && scroll) |=>
      (row_q == ROW_W'(SCREEN_ROWS - 1)) && (col_q == '0))
    else $error("cursor not on last row after scroll");

endmodule

// ===== rtl/text_console_writer.sv =====
// top level of the text console writer
// joins the controller and the datapath; depends on tcw_pkg, tcw_ctrl, tcw_datapath
//
// An 80x25 text screen of 16-bit cells (attribute in the high byte, character in the
// low byte) with a cursor. After reset a clearing pass writes blanks into all 2000
// cells, one a cycle, and no item is taken until that pass ends. One item is worked
// on at a time through the single write port of the screen memory: put_char, newline,
// backspace, write_cell and the unused codes finish in the execute state if the output
// register is free, read_cell in the response state (the memory read is registered).
// A put_char or newline that leaves the last row scrolls: rows 1 to 24 move up one
// row, a drain state writes the last copied cell and the last row is blanked. A clear
// blanks all 2000 cells. A finished result waits in the output register while the next
// item is taken. The attribute register may be written at any time the block is idle.
module text_console_writer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: char_code[7:0], cell_attr[15:8], col_in[22:16], row_in[27:23], zero[31:28]
  input  logic [tcw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action[2:0]
  input  logic [tcw_pkg::ACT_W-1:0]      s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: cursor_index[10:0], serial_byte[18:11], cell_entry[34:19], zero[39:35]
  output logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: serial_valid
  output logic                           m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data_i
);
  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
